// ----- design/rtbl_pkg.sv -----
`default_nettype none

package rtbl_pkg;

    // Geometry of the tag buffer.
    localparam int SETS      = 128;
    localparam int WAYS      = 8;
    localparam int TAG_BITS  = 48;
    localparam int ENTRIES   = SETS * WAYS;

    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int WAY_CNT_W = $clog2(WAYS + 1);
    localparam int RANK_W    = $clog2(WAYS);
    localparam int PIN_CNT_W = $clog2(ENTRIES + 1);

    // Stream widths, padded to whole bytes.
    localparam int IN_FIELD_W  = 2 * TAG_BITS + 1;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 1 + WAY_CNT_W + 1 + 1 + PIN_CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_PAIR   = 2'd1,
        OP_INSERT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                pinned;
        logic [RANK_W-1:0]   rank;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    // Running result of a scan over the ways of one set.
    typedef struct packed {
        logic                 found;
        logic [WAY_CNT_W-1:0] found_way;
        logic                 fits;
        logic [WAY_CNT_W-1:0] fit_cnt;
        logic                 victim_ok;
        logic [WAY_W-1:0]     victim;
        logic [RANK_W-1:0]    best_rank;
    } scan_acc_t;

    // Result beat, first field in the lowest bits.
    typedef struct packed {
        logic [PIN_CNT_W-1:0] pinned_count;
        logic                 insert_failed;
        logic                 room;
        logic [WAY_CNT_W-1:0] found_way;
        logic                 found;
    } result_t;

    function automatic row_t reset_row();
        row_t r;
        for (int w = 0; w < WAYS; w++)
        begin
            r[w].tag    = '0;
            r[w].pinned = 1'b0;
            r[w].rank   = RANK_W'(w);
        end
        return r;
    endfunction

    function automatic scan_acc_t scan_init();
        scan_acc_t a;
        a.found     = 1'b0;
        a.found_way = WAY_CNT_W'(WAYS);
        a.fits      = 1'b0;
        a.fit_cnt   = '0;
        a.victim_ok = 1'b0;
        a.victim    = '0;
        a.best_rank = '0;
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- design/remap_tag_buffer_lru_unit.sv -----
`default_nettype none

// Set-associative tag buffer of 128 sets by 8 ways with pinned entries and
// per-set LRU ranks. Each input beat carries an opcode in s_tuser and the tags
// and pin mark in s_tdata; exactly one result beat comes back per input beat,
// in order. The set is the low seven bits of the tag. A set row lives in one
// RAM word, and a single compare unit walks its ways one per cycle. An item
// reads, loads and scans its set row, then loads the result register; a pair
// check over two sets does so for both, and a clear only finishes. The block
// accepts no new beat while an item is in flight, but it does accept one while
// a finished result still waits on m_tready. Reset and clear take effect at
// once through one valid flag per set: a set that was never written since
// reads as the cleared state (tag 0, unpinned, rank equal to the way), so
// tag 0 matches cleared entries.
module remap_tag_buffer_lru_unit
    import rtbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata fields from bit 0 up: tag_a, tag_b, pin_mark, zero padding.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0 up: opcode.
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata fields from bit 0 up: found, found_way, room, insert_failed,
    // pinned_count, zero padding.
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_READ_A = 8'b0000_0010,
        ST_LOAD_A = 8'b0000_0100,
        ST_SCAN_A = 8'b0000_1000,
        ST_READ_B = 8'b0001_0000,
        ST_LOAD_B = 8'b0010_0000,
        ST_SCAN_B = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Item being worked on.
    op_t                 op_reg;
    logic [TAG_BITS-1:0] tag_a_reg;
    logic [TAG_BITS-1:0] tag_b_reg;
    logic                pin_reg;

    logic [SET_W-1:0]    set_a;
    logic [SET_W-1:0]    set_b;
    logic                same_set;

    // Working copy of the set row and the scan results of both sets.
    row_t                row_reg;
    logic                rd_ok_reg;
    logic [WAY_W-1:0]    way_reg;
    logic                last_way;
    scan_acc_t           acc_a_reg;
    scan_acc_t           acc_b_reg;
    scan_acc_t           acc_in;
    scan_acc_t           acc_out;

    // One valid flag per set; a clear drops them all at once.
    logic [SETS-1:0]     set_valid_reg, set_valid_next;
    logic [PIN_CNT_W-1:0] pinned_total_reg, pinned_total_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    result_t             result_reg;
    result_t             result_next;
    logic                fire;

    // RAM port signals.
    logic                ram_we;
    logic                ram_re;
    logic [SET_W-1:0]    ram_raddr;
    logic [ROW_W-1:0]    ram_rdata;
    row_t                new_row;
    logic                pin_inc;
    logic                ins_failed;

    logic                accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, result_reg};

    assign set_a    = tag_a_reg[SET_W-1:0];
    assign set_b    = tag_b_reg[SET_W-1:0];
    assign same_set = (set_a == set_b);
    assign last_way = (way_reg == WAY_W'(WAYS - 1));

    // The result register is free when empty or when its beat leaves now.
    assign fire = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // Row storage: one word per set.
    assign ram_re    = (state_reg == ST_READ_A) || (state_reg == ST_READ_B);
    assign ram_raddr = (state_reg == ST_READ_B) ? set_b : set_a;
    assign ram_we    = fire && (op_reg == OP_INSERT) && !ins_failed;

    rtbl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (set_a),
        .wr_data (new_row),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The shared compare unit sees one way of the row per cycle.
    assign acc_in = (state_reg == ST_SCAN_B) ? acc_b_reg : acc_a_reg;

    rtbl_way_cmp u_way_cmp (
        .entry   (row_reg[way_reg]),
        .way     (way_reg),
        .key_tag ((state_reg == ST_SCAN_B) ? tag_b_reg : tag_a_reg),
        .alt_tag (tag_b_reg),
        .acc_in  (acc_in),
        .acc_out (acc_out)
    );

    rtbl_update u_update (
        .row_in  (row_reg),
        .acc     (acc_a_reg),
        .tag     (tag_a_reg),
        .pin     (pin_reg),
        .row_out (new_row),
        .pin_inc (pin_inc),
        .failed  (ins_failed)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op_t'(s_tuser) == OP_CLEAR) ? ST_FINISH : ST_READ_A;
                end
            end
            ST_READ_A: state_next = ST_LOAD_A;
            ST_LOAD_A: state_next = ST_SCAN_A;
            ST_SCAN_A:
            begin
                if (last_way)
                begin
                    state_next = ((op_reg == OP_PAIR) && !same_set) ? ST_READ_B : ST_FINISH;
                end
            end
            ST_READ_B: state_next = ST_LOAD_B;
            ST_LOAD_B: state_next = ST_SCAN_B;
            ST_SCAN_B:
            begin
                if (last_way)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result of the item, formed in the finishing cycle.
    always_comb
    begin
        result_next               = '0;
        result_next.found_way     = WAY_CNT_W'(WAYS);
        pinned_total_next         = pinned_total_reg;
        set_valid_next            = set_valid_reg;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                result_next.found     = acc_a_reg.found;
                result_next.found_way = acc_a_reg.found_way;
                result_next.room      = acc_a_reg.fits;
            end
            OP_PAIR:
            begin
                result_next.found     = acc_a_reg.found;
                result_next.found_way = acc_a_reg.found_way;
                result_next.room      = same_set ? (acc_a_reg.fit_cnt >= WAY_CNT_W'(2))
                                                 : (acc_a_reg.fits && acc_b_reg.fits);
            end
            OP_INSERT:
            begin
                result_next.found         = acc_a_reg.found;
                result_next.found_way     = acc_a_reg.found_way;
                result_next.room          = acc_a_reg.fits;
                result_next.insert_failed = ins_failed;
                pinned_total_next         = pinned_total_reg + PIN_CNT_W'(pin_inc);
                if (!ins_failed)
                begin
                    set_valid_next[set_a] = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                pinned_total_next = '0;
                set_valid_next    = '0;
            end
            default:
            begin
                pinned_total_next = pinned_total_reg;
            end
        endcase
        result_next.pinned_count = pinned_total_next;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            set_valid_reg    <= '0;
            pinned_total_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (fire)
            begin
                set_valid_reg    <= set_valid_next;
                pinned_total_reg <= pinned_total_next;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(s_tuser);
            tag_a_reg <= s_tdata[TAG_BITS-1:0];
            tag_b_reg <= s_tdata[2*TAG_BITS-1:TAG_BITS];
            pin_reg   <= s_tdata[2*TAG_BITS];
        end
        if (ram_re)
        begin
            rd_ok_reg <= set_valid_reg[ram_raddr];
        end
        if ((state_reg == ST_LOAD_A) || (state_reg == ST_LOAD_B))
        begin
            row_reg <= rd_ok_reg ? row_t'(ram_rdata) : reset_row();
            way_reg <= '0;
        end
        if (state_reg == ST_LOAD_A)
        begin
            acc_a_reg <= scan_init();
        end
        if (state_reg == ST_LOAD_B)
        begin
            acc_b_reg <= scan_init();
        end
        if ((state_reg == ST_SCAN_A) || (state_reg == ST_SCAN_B))
        begin
            way_reg <= way_reg + WAY_W'(1);
        end
        if (state_reg == ST_SCAN_A)
        begin
            acc_a_reg <= acc_out;
        end
        if (state_reg == ST_SCAN_B)
        begin
            acc_b_reg <= acc_out;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    // A found tag always names a real way.
    a_found_way: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && result_reg.found) |-> (result_reg.found_way < WAY_CNT_W'(WAYS)))
        else $error("found result names no way");

    // A failed insert leaves no room and changes no row.
    a_failed_room: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && result_reg.insert_failed) |-> !result_reg.room)
        else $error("failed insert reports room");

    // Only a finishing insert writes a set row back.
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_FINISH) && (op_reg == OP_INSERT)))
        else $error("row write outside an insert");

    // Pinned entries never outnumber the entries.
    a_pin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pinned_total_reg <= PIN_CNT_W'(ENTRIES))
        else $error("pinned count out of range");

    // A non-clear item starts with a row read.
    a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(s_tuser) != OP_CLEAR)) |=> (state_reg == ST_READ_A))
        else $error("item did not start with a row read");

endmodule

`default_nettype wire

// ----- design/rtbl_ram.sv -----
`default_nettype none

module rtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/rtbl_way_cmp.sv -----
`default_nettype none

// Shared per-way compare unit: folds one entry into the running scan result.
module rtbl_way_cmp
    import rtbl_pkg::*;
(
    input  wire entry_t              entry,
    input  wire logic [WAY_W-1:0]    way,
    input  wire logic [TAG_BITS-1:0] key_tag,
    input  wire logic [TAG_BITS-1:0] alt_tag,
    input  wire scan_acc_t           acc_in,
    output scan_acc_t                acc_out
);

    logic key_hit;
    logic alt_hit;

    assign key_hit = (entry.tag == key_tag);
    assign alt_hit = (entry.tag == alt_tag);

    always_comb
    begin
        acc_out = acc_in;
        if (key_hit && !acc_in.found)
        begin
            acc_out.found     = 1'b1;
            acc_out.found_way = WAY_CNT_W'(way);
        end
        if (!entry.pinned || key_hit)
        begin
            acc_out.fits = 1'b1;
        end
        if (!entry.pinned || key_hit || alt_hit)
        begin
            acc_out.fit_cnt = acc_in.fit_cnt + WAY_CNT_W'(1);
        end
        if (!entry.pinned && (entry.rank >= acc_in.best_rank))
        begin
            acc_out.victim_ok = 1'b1;
            acc_out.victim    = way;
            acc_out.best_rank = entry.rank;
        end
    end

endmodule

`default_nettype wire

// ----- design/rtbl_update.sv -----
`default_nettype none

// Builds the new contents of a set for an insert: pin, refresh or replace.
module rtbl_update
    import rtbl_pkg::*;
(
    input  wire row_t                row_in,
    input  wire scan_acc_t           acc,
    input  wire logic [TAG_BITS-1:0] tag,
    input  wire logic                pin,
    output row_t                     row_out,
    output logic                     pin_inc,
    output logic                     failed
);

    row_t              row_mid;
    logic              do_touch;
    logic [WAY_W-1:0]  tgt;
    logic [RANK_W-1:0] tgt_rank;

    always_comb
    begin
        row_mid  = row_in;
        do_touch = 1'b0;
        pin_inc  = 1'b0;
        failed   = 1'b0;
        tgt      = acc.victim;
        if (acc.found)
        begin
            tgt = acc.found_way[WAY_W-1:0];
            if (pin)
            begin
                pin_inc             = !row_in[tgt].pinned;
                row_mid[tgt].pinned = 1'b1;
            end
            else
            begin
                do_touch = !row_in[tgt].pinned;
            end
        end
        else if (!acc.victim_ok)
        begin
            failed = 1'b1;
        end
        else
        begin
            row_mid[tgt].tag    = tag;
            row_mid[tgt].pinned = pin;
            pin_inc             = pin;
            do_touch            = !pin;
        end
    end

    assign tgt_rank = row_mid[tgt].rank;

    // Ages every unpinned entry younger than the target, then makes it the newest.
    always_comb
    begin
        row_out = row_mid;
        if (do_touch)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!row_mid[w].pinned && (row_mid[w].rank < tgt_rank))
                begin
                    row_out[w].rank = row_mid[w].rank + RANK_W'(1);
                end
            end
            row_out[tgt].rank = '0;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Stream-level test of the set-associative tag buffer. A directed table runs
// first: reset contents, tag extremes, the existing-entry insert cases, a set
// filled with pinned entries, the pair check that shares one set, and clear.
// A random run follows. Its tags are drawn from a few hot sets so that hits,
// evictions and full sets happen often. A reference predictor inside this
// module tracks every entry and checks each result beat field by field.
module tb_top;
    import rtbl_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    // During the last stretch of the run both sides stream without any idling.
    localparam int QUIET_ITEMS  = 150;
    localparam int HOT_SETS     = 3;
    localparam int DIRECTED_N   = 25;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata fields from bit 0 up: tag_a, tag_b, pin_mark, zero padding.
    logic [IN_DATA_W-1:0]  s_tdata;
    // s_tuser fields from bit 0 up: opcode.
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata fields from bit 0 up: found, found_way, room, insert_failed,
    // pinned_count, zero padding.
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the buffer contents, kept in step with accepted beats.
    logic [TAG_BITS-1:0] buf_tag    [ENTRIES];
    logic                buf_pinned [ENTRIES];
    logic [RANK_W-1:0]   buf_rank   [ENTRIES];
    int                  buf_pin_total;

    // Results the block still owes, oldest first.
    result_t predicted_beats [$];
    int      mismatch_count = 0;
    bit      quiet = 1'b0;
    int      stall_left = 0;

    // One row of the directed table. Where known is set, the expected result is
    // written out in the row; otherwise it comes from the predictor.
    typedef struct {
        op_t                 op;
        logic [TAG_BITS-1:0] tag_a;
        logic [TAG_BITS-1:0] tag_b;
        logic                pin;
        bit                  known;
        int                  found;
        int                  way;
        int                  room;
        int                  fail;
        int                  count;
    } stim_row_t;

    // Set 0 holds tags that are multiples of 0x80, set 1 those one above, and
    // the all-ones tag falls into the last set. After reset every way of a set
    // holds tag 0, unpinned, with rank equal to its way.
    stim_row_t directed_rows [DIRECTED_N] = '{
        // Tag 0 matches the cleared entries; way 0 is the lowest match.
        '{OP_LOOKUP, 48'h0,            48'h0,            1'b0, 1'b1, 1, 0,    1, 0, 0},
        '{OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'h0,          1'b0, 1'b1, 0, WAYS, 1, 0, 0},
        '{OP_PAIR,   48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 0, WAYS, 1, 0, 0},
        '{OP_PAIR,   48'h80,           48'h81,           1'b0, 1'b1, 0, WAYS, 1, 0, 0},
        // New unpinned entry replaces the way of highest rank, way 7.
        '{OP_INSERT, 48'h81,           48'h0,            1'b0, 1'b1, 0, WAYS, 1, 0, 0},
        '{OP_INSERT, 48'h81,           48'h0,            1'b0, 1'b1, 1, 7,    1, 0, 0},
        '{OP_INSERT, 48'h101,          48'h0,            1'b0, 1'b0, 0, 0,    0, 0, 0},
        // Refresh of an existing unpinned entry moves it back to rank 0.
        '{OP_INSERT, 48'h81,           48'h0,            1'b0, 1'b0, 0, 0,    0, 0, 0},
        // Pinning an existing entry, then touching and re-pinning it: no change.
        '{OP_INSERT, 48'h81,           48'h0,            1'b1, 1'b1, 1, 7,    1, 0, 1},
        '{OP_INSERT, 48'h81,           48'h0,            1'b0, 1'b1, 1, 7,    1, 0, 1},
        '{OP_INSERT, 48'h81,           48'h0,            1'b1, 1'b1, 1, 7,    1, 0, 1},
        // Fill set 0 with pinned entries: tag 0 in way 0, then seven new tags.
        '{OP_INSERT, 48'h0,            48'h0,            1'b1, 1'b1, 1, 0,    1, 0, 2},
        '{OP_INSERT, 48'h80,           48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h100,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h180,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h200,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h280,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h300,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        '{OP_INSERT, 48'h380,          48'h0,            1'b1, 1'b0, 0, 0,    0, 0, 0},
        // Set 0 is fully pinned: the insert fails and nothing changes.
        '{OP_INSERT, 48'h400,          48'h0,            1'b0, 1'b1, 0, WAYS, 0, 1, 9},
        '{OP_LOOKUP, 48'h400,          48'h0,            1'b0, 1'b1, 0, WAYS, 0, 0, 9},
        // Shared set: only one way counts for the pair, so there is no room.
        '{OP_PAIR,   48'h400,          48'h380,          1'b0, 1'b1, 0, WAYS, 0, 0, 9},
        '{OP_PAIR,   48'h80,           48'h380,          1'b0, 1'b0, 0, 0,    0, 0, 0},
        '{OP_CLEAR,  48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1, 0, WAYS, 0, 0, 0},
        '{OP_LOOKUP, 48'h81,           48'h0,            1'b0, 1'b1, 0, WAYS, 1, 0, 0}
    };

    remap_tag_buffer_lru_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic void buf_clear();
        for (int i = 0; i < ENTRIES; i++)
        begin
            buf_tag[i]    = '0;
            buf_pinned[i] = 1'b0;
            buf_rank[i]   = RANK_W'(i % WAYS);
        end
        buf_pin_total = 0;
    endfunction

    // A tag fits in its set when some way is unpinned or already holds it.
    function automatic bit buf_fits(int base, logic [TAG_BITS-1:0] tag);
        for (int w = 0; w < WAYS; w++)
            if (!buf_pinned[base + w] || buf_tag[base + w] == tag)
                return 1'b1;
        return 1'b0;
    endfunction

    // Make a way most recently used; unpinned ways that were more recent age by one.
    function automatic void buf_touch(int base, int way);
        logic [RANK_W-1:0] old_rank;
        old_rank = buf_rank[base + way];
        for (int w = 0; w < WAYS; w++)
            if (!buf_pinned[base + w] && buf_rank[base + w] < old_rank)
                buf_rank[base + w] = buf_rank[base + w] + 1'b1;
        buf_rank[base + way] = '0;
    endfunction

    // Applies one beat to the shadow buffer and returns the result it must give.
    function automatic result_t tag_buffer_predict(op_t op, logic [TAG_BITS-1:0] ta,
                                                   logic [TAG_BITS-1:0] tb, logic pin);
        result_t           r;
        int                base_a;
        int                base_b;
        int                hit;
        int                victim;
        int                usable;
        logic [RANK_W-1:0] best;
        base_a = int'(ta[SET_W-1:0]) * WAYS;
        base_b = int'(tb[SET_W-1:0]) * WAYS;
        hit    = WAYS;
        r      = '0;
        if (op != OP_CLEAR)
            for (int w = WAYS - 1; w >= 0; w--)
                if (buf_tag[base_a + w] == ta)
                    hit = w;
        case (op)
            OP_LOOKUP:
                r.room = buf_fits(base_a, ta);
            OP_PAIR:
            begin
                if (base_a != base_b)
                    r.room = buf_fits(base_a, ta) && buf_fits(base_b, tb);
                else
                begin
                    // Both tags share the set, so two usable ways are needed.
                    usable = 0;
                    for (int w = 0; w < WAYS; w++)
                        if (!buf_pinned[base_a + w] || buf_tag[base_a + w] == ta
                            || buf_tag[base_a + w] == tb)
                            usable++;
                    r.room = (usable >= 2);
                end
            end
            OP_INSERT:
            begin
                r.room = buf_fits(base_a, ta);
                if (hit < WAYS)
                begin
                    if (pin)
                    begin
                        if (!buf_pinned[base_a + hit])
                            buf_pin_total++;
                        buf_pinned[base_a + hit] = 1'b1;
                    end
                    else if (!buf_pinned[base_a + hit])
                        buf_touch(base_a, hit);
                end
                else
                begin
                    // Oldest unpinned way wins; on a tie the higher way.
                    victim = WAYS;
                    best   = '0;
                    for (int w = 0; w < WAYS; w++)
                        if (!buf_pinned[base_a + w] && buf_rank[base_a + w] >= best)
                        begin
                            best   = buf_rank[base_a + w];
                            victim = w;
                        end
                    if (victim == WAYS)
                        r.insert_failed = 1'b1;
                    else
                    begin
                        buf_tag[base_a + victim]    = ta;
                        buf_pinned[base_a + victim] = pin;
                        if (pin)
                            buf_pin_total++;
                        else
                            buf_touch(base_a, victim);
                    end
                end
            end
            default:
                buf_clear();
        endcase
        r.found        = (hit < WAYS);
        r.found_way    = WAY_CNT_W'(hit);
        r.pinned_count = PIN_CNT_W'(buf_pin_total);
        return r;
    endfunction

    // Mostly tags of one set with a small spread of upper bits, so that the
    // same tags come back; now and then a tag with every bit random.
    function automatic logic [TAG_BITS-1:0] pick_tag(logic [SET_W-1:0] set_idx);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return wide[TAG_BITS-1:0];
        return (TAG_BITS'($urandom_range(0, 10)) << SET_W) | TAG_BITS'(set_idx);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h", field, got, want);
        mismatch_count++;
    endtask

    // Sends one beat, with an idle burst ahead of it now and then, and records
    // the result it is owed once the beat is taken.
    task automatic drive_beat(op_t op, logic [TAG_BITS-1:0] ta, logic [TAG_BITS-1:0] tb,
                              logic pin, bit known, result_t known_result);
        result_t predicted;
        int      gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({pin, tb, ta});
        do
            @(posedge clk);
        while (!s_tready);
        predicted = tag_buffer_predict(op, ta, tb, pin);
        predicted_beats.push_back(known ? known_result : predicted);
    endtask

    // Result side: m_tready is held low in stall bursts that start at random outside the quiet stretch.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Every result beat taken is compared with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[OUT_FIELD_W-1:0]);
            if (predicted_beats.size() == 0)
                report_mismatch("unrequested beat", 32'(got), 32'd0);
            else
            begin
                want = predicted_beats.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.found_way !== want.found_way)
                    report_mismatch("found_way", 32'(got.found_way), 32'(want.found_way));
                if (got.room !== want.room)
                    report_mismatch("room", 32'(got.room), 32'(want.room));
                if (got.insert_failed !== want.insert_failed)
                    report_mismatch("insert_failed", 32'(got.insert_failed),
                                    32'(want.insert_failed));
                if (got.pinned_count !== want.pinned_count)
                    report_mismatch("pinned_count", 32'(got.pinned_count),
                                    32'(want.pinned_count));
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t           row;
        result_t             known_result;
        logic [SET_W-1:0]    hot_set [HOT_SETS];
        logic [SET_W-1:0]    set_a;
        logic [TAG_BITS-1:0] ta;
        logic [TAG_BITS-1:0] tb;
        op_t                 op;
        int                  roll;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOOKUP;
        buf_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row                        = directed_rows[i];
            known_result.found         = 1'(row.found);
            known_result.found_way     = WAY_CNT_W'(row.way);
            known_result.room          = 1'(row.room);
            known_result.insert_failed = 1'(row.fail);
            known_result.pinned_count  = PIN_CNT_W'(row.count);
            drive_beat(row.op, row.tag_a, row.tag_b, row.pin, row.known, known_result);
        end

        // Random run. The hot sets change after every clear so that the
        // buffer fills up again in fresh places.
        for (int k = 0; k < HOT_SETS; k++)
            hot_set[k] = SET_W'($urandom_range(0, SETS - 1));
        known_result = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            set_a = hot_set[$urandom_range(0, HOT_SETS - 1)];
            ta    = pick_tag(set_a);
            // Half of the pair checks stay inside the set of tag_a.
            if ($urandom_range(0, 1) == 0)
                tb = pick_tag(ta[SET_W-1:0]);
            else
                tb = pick_tag(hot_set[$urandom_range(0, HOT_SETS - 1)]);
            roll = $urandom_range(0, 99);
            if (roll < 45)
                op = OP_INSERT;
            else if (roll < 68)
                op = OP_LOOKUP;
            else if (roll < 96)
                op = OP_PAIR;
            else
                op = OP_CLEAR;
            drive_beat(op, ta, tb, ($urandom_range(0, 3) == 0), 1'b0, known_result);
            if (op == OP_CLEAR)
                for (int k = 0; k < HOT_SETS; k++)
                    hot_set[k] = SET_W'($urandom_range(0, SETS - 1));
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray beat.
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
